### rtl/pit_pkg.sv
// Shared definitions for the periodic interval timer.
// Operation codes, register map, default widths and the controller/datapath
// command and status structs. No dependencies.
package pit_pkg;

   localparam int DEF_TIME_BITS = 64;
   localparam int FIELD_BITS    = 64;
   localparam int PERIOD_BITS   = 32;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [1:0] FUNC_ACTIVATE     = 2'd0;
   localparam logic [1:0] FUNC_REFRESH      = 2'd1;
   localparam logic [1:0] FUNC_REFRESH_DLT  = 2'd2;
   localparam logic [1:0] FUNC_REFRESH_REM  = 2'd3;

   localparam logic REG_PERIOD = 1'b0;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } pit_cmd_type;

   typedef struct packed {
      logic fast;
   } pit_sts_type;

endpackage

### rtl/pit_csr.sv
// Configuration register block of the periodic interval timer.
// Holds the period register behind an APB-style port; uses pit_pkg.
module pit_csr
   import pit_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready,
   output logic [PERIOD_BITS-1:0]   period
);

   logic [PERIOD_BITS-1:0] period_ff;
   logic [PERIOD_BITS-1:0] period_in;
   logic                   wr_en;

   assign csr_pready = 1'b1;
   assign wr_en = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_comb begin
      period_in = period_ff;
      if (wr_en && csr_paddr[2] == REG_PERIOD) begin
         period_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         period_ff <= '0;
      end else begin
         period_ff <= period_in;
      end
   end

   always_comb begin
      if (csr_paddr[2] == REG_PERIOD) begin
         csr_prdata = period_ff;
      end else begin
         csr_prdata = '0;
      end
   end

   assign period = period_ff;

endmodule

### rtl/pit_ctrl.sv
// Sequencer of the periodic interval timer.
// Steps the datapath through load, one remainder bit per cycle, and commit,
// and owns the result valid flag; uses pit_pkg.
module pit_ctrl
   import pit_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  pit_sts_type sts,
   output pit_cmd_type cmd
);

   localparam int CNT_BITS = $clog2(TIME_BITS);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_DIV  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;
   logic                valid_ff, valid_in;
   logic                out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = valid_ff;
   assign out_free   = ~valid_ff | rsp_tready;

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      valid_in   = valid_ff & ~rsp_tready;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               cnt_in   = CNT_BITS'(TIME_BITS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            // Activate, zero period and a time before the base need no remainder.
            if (sts.fast) begin
               state_in = ST_DONE;
            end else begin
               cmd.step = 1'b1;
               if (cnt_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  cnt_in = cnt_ff - 1'b1;
               end
            end
         end
         ST_DONE: begin
            if (out_free) begin
               cmd.commit = 1'b1;
               valid_in   = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

endmodule

### rtl/pit_dp.sv
// Datapath of the periodic interval timer.
// Base time register, elapsed-time subtractor, bit-serial restoring remainder
// unit and the result register; uses pit_pkg.
module pit_dp
   import pit_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  pit_cmd_type            cmd,
   output pit_sts_type            sts,
   input  logic [1:0]             req_func,
   input  logic [FIELD_BITS-1:0]  req_now,
   input  logic [PERIOD_BITS-1:0] period,
   output logic                   rsp_expired,
   output logic [FIELD_BITS-1:0]  rsp_time_value,
   output logic                   rsp_zero_period_error
);

   logic [TIME_BITS-1:0]   base_ff, base_in;
   logic [TIME_BITS-1:0]   now_ff, now_in;
   logic [TIME_BITS-1:0]   elapsed_ff, elapsed_in;
   logic [TIME_BITS-1:0]   dvd_ff, dvd_in;
   logic [PERIOD_BITS-1:0] rem_ff, rem_in;
   logic [1:0]             func_ff, func_in;
   logic                   fast_ff, fast_in;
   logic                   exp_ff, exp_in;
   logic [FIELD_BITS-1:0]  val_ff, val_in;
   logic                   err_ff, err_in;

   logic [TIME_BITS-1:0]   now_t;
   logic [PERIOD_BITS:0]   trial;
   logic [PERIOD_BITS:0]   per_ext;
   logic                   hit;
   logic                   per_zero;

   assign now_t    = req_now[TIME_BITS-1:0];
   assign per_zero = (period == '0);
   assign per_ext  = {1'b0, period};
   assign trial    = {rem_ff, dvd_ff[TIME_BITS-1]};
   assign hit      = FIELD_BITS'(elapsed_ff) >= FIELD_BITS'(period);

   always_comb begin
      base_in    = base_ff;
      now_in     = now_ff;
      elapsed_in = elapsed_ff;
      dvd_in     = dvd_ff;
      rem_in     = rem_ff;
      func_in    = func_ff;
      fast_in    = fast_ff;
      exp_in     = exp_ff;
      val_in     = val_ff;
      err_in     = err_ff;

      if (cmd.load) begin
         func_in    = req_func;
         now_in     = now_t;
         elapsed_in = now_t - base_ff;
         dvd_in     = now_t - base_ff;
         rem_in     = '0;
         fast_in    = (req_func == FUNC_ACTIVATE) | per_zero | (now_t < base_ff);
      end

      // One quotient bit per cycle; the partial remainder stays below the period.
      if (cmd.step) begin
         dvd_in = dvd_ff << 1;
         if (trial >= per_ext) begin
            rem_in = PERIOD_BITS'(trial - per_ext);
         end else begin
            rem_in = trial[PERIOD_BITS-1:0];
         end
      end

      if (cmd.commit) begin
         exp_in = 1'b0;
         val_in = '0;
         err_in = 1'b0;
         if (func_ff == FUNC_ACTIVATE) begin
            if (!per_zero) begin
               base_in = now_ff;
            end
         end else if (per_zero) begin
            err_in = 1'b1;
         end else if (!fast_ff) begin
            exp_in = hit;
            if (hit) begin
               // Move the base back by the remainder so the phase does not drift.
               base_in = TIME_BITS'(FIELD_BITS'(now_ff) - FIELD_BITS'(rem_ff));
            end
            case (func_ff)
               FUNC_REFRESH_DLT: val_in = FIELD_BITS'(elapsed_ff);
               FUNC_REFRESH_REM: val_in = FIELD_BITS'(rem_ff);
               default:          val_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= '0;
      end else begin
         base_ff <= base_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff     <= now_in;
      elapsed_ff <= elapsed_in;
      dvd_ff     <= dvd_in;
      rem_ff     <= rem_in;
      func_ff    <= func_in;
      fast_ff    <= fast_in;
      exp_ff     <= exp_in;
      val_ff     <= val_in;
      err_ff     <= err_in;
   end

   assign sts.fast              = fast_ff;
   assign rsp_expired           = exp_ff;
   assign rsp_time_value        = val_ff;
   assign rsp_zero_period_error = err_ff;

endmodule

### rtl/periodic_interval_timer.sv
// Top level of the periodic interval timer.
// Joins pit_csr, pit_ctrl and pit_dp; uses pit_pkg.
//
//   channel   direction  handshake               payload
//   req       in         req_tvalid/req_tready   tuser: func; tdata: now_time
//   rsp       out        rsp_tvalid/rsp_tready   tdata: expired, time_value, error
//   csr       in         psel/penable/pready     period register at byte 0
//
// A refresh runs the remainder unit, one elapsed-time bit per cycle, and then
// commits and raises rsp_tvalid; the next item is taken only after the commit,
// so items do not overlap. Activate, a zero period or a time before the base
// skip the remainder. Reset is synchronous and clears the base time and the
// period. A waiting result does not block acceptance of the next item; only
// the final commit waits for it.
module periodic_interval_timer
   import pit_pkg::*;
#(
   parameter int TIME_BITS = DEF_TIME_BITS
)
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // tdata bits: [63:0] now_time, [71:64] zero fill
   input  logic [71:0]              req_tdata,
   // tuser bits: [1:0] func
   input  logic [1:0]               req_tuser,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // tdata bits: [0] expired, [64:1] time_value, [65] zero_period_error, [71:66] zero
   output logic [71:0]              rsp_tdata,
   input  logic                     csr_psel,
   input  logic                     csr_penable,
   input  logic                     csr_pwrite,
   input  logic [CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [CSR_DATA_BITS-1:0] csr_prdata,
   output logic                     csr_pready
);

   pit_cmd_type            cmd;
   pit_sts_type            sts;
   logic [PERIOD_BITS-1:0] period;
   logic                   expired;
   logic [FIELD_BITS-1:0]  time_value;
   logic                   zero_period_error;

   pit_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .period      (period)
   );

   pit_ctrl #(
      .TIME_BITS (TIME_BITS)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   pit_dp #(
      .TIME_BITS (TIME_BITS)
   ) u_dp (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .sts                   (sts),
      .req_func              (req_tuser),
      .req_now               (req_tdata[FIELD_BITS-1:0]),
      .period                (period),
      .rsp_expired           (expired),
      .rsp_time_value        (time_value),
      .rsp_zero_period_error (zero_period_error)
   );

   assign rsp_tdata = {6'b0, zero_period_error, time_value, expired};

endmodule

### test/tb_periodic_interval_timer.sv
// Self-checking testbench for periodic_interval_timer: timer items go in on the req stream,
// and each result is checked against an in-bench model of the base time and period.
// Depends on pit_pkg and the periodic_interval_timer RTL only.
module tb_periodic_interval_timer;
   import pit_pkg::*;

   localparam int IDLE_LIMIT   = 2000;
   localparam int DRAIN_CYCLES = 70;

   typedef struct packed {
      logic        expired;
      logic [63:0] time_value;
      logic        zero_err;
   } timer_result_type;

   logic                     clock       = 1'b0;
   logic                     reset       = 1'b1;
   logic                     req_tvalid  = 1'b0;
   logic                     req_tready;
   // tdata bits: [63:0] now_time, [71:64] zero fill
   logic [71:0]              req_tdata   = '0;
   // tuser bits: [1:0] func
   logic [1:0]               req_tuser   = FUNC_ACTIVATE;
   logic                     rsp_tvalid;
   logic                     rsp_tready  = 1'b0;
   // tdata bits: [0] expired, [64:1] time_value, [65] zero_period_error, [71:66] zero
   logic [71:0]              rsp_tdata;
   logic                     csr_psel    = 1'b0;
   logic                     csr_penable = 1'b0;
   logic                     csr_pwrite  = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_paddr   = '0;
   logic [CSR_DATA_BITS-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_BITS-1:0] csr_prdata;
   logic                     csr_pready;

   // Model state, kept in step with the block as items are accepted.
   logic [63:0]      model_base   = '0;
   logic [31:0]      model_period = '0;
   timer_result_type pending_results[$];
   timer_result_type oldest;
   int               mismatch_count = 0;
   int               idle_cycles    = 0;
   bit               steady_flow    = 1'b0;

   periodic_interval_timer dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic timer_result_type timer_predict(input logic [1:0] op,
                                                      input logic [63:0] now);
      timer_result_type r;
      logic [63:0]      elapsed;
      logic [63:0]      rem;
      r = '0;
      if (op == FUNC_ACTIVATE) begin
         if (model_period != 0) model_base = now;
      end else if (model_period == 0) begin
         r.zero_err = 1'b1;
      end else if (now >= model_base) begin
         elapsed   = now - model_base;
         rem       = elapsed % {32'd0, model_period};
         r.expired = (elapsed >= {32'd0, model_period});
         // Realign to the last period boundary so the phase never drifts.
         if (r.expired) model_base = now - rem;
         if (op == FUNC_REFRESH_DLT) r.time_value = elapsed;
         else if (op == FUNC_REFRESH_REM) r.time_value = rem;
      end
      return r;
   endfunction

   function automatic void note_mismatch(input string what, input logic [63:0] want,
                                         input logic [63:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch in %s: expected %h, got %h", what, want, got);
   endfunction

   task automatic send_item(input logic [1:0] op, input logic [63:0] now);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 8);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {8'd0, now};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(timer_predict(op, now));
   endtask

   // Always waits on the clock before checking, so valid is never lowered and raised in one step.
   task automatic wait_drained();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic check_period_readback(input logic [31:0] want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= {REG_PERIOD, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== want) note_mismatch("period readback", want, csr_prdata);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic write_period(input logic [31:0] value);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {REG_PERIOD, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      model_period = value;
      check_period_readback(value);
   endtask

   task automatic test_reset_defaults();
      check_period_readback(32'd0);
      // With the period still zero, activate is ignored and every refresh flags an error.
      send_item(FUNC_ACTIVATE, 64'h1234);
      send_item(FUNC_REFRESH, 64'h1234);
      send_item(FUNC_REFRESH_DLT, '1);
      send_item(FUNC_REFRESH_REM, 64'd0);
   endtask

   task automatic test_directed_cases();
      write_period(32'd1);
      send_item(FUNC_ACTIVATE, 64'd0);
      send_item(FUNC_REFRESH_DLT, 64'd0);
      send_item(FUNC_REFRESH_REM, 64'd1);
      send_item(FUNC_REFRESH_DLT, '1);
      send_item(FUNC_REFRESH, 64'd0);
      write_period(32'hFFFF_FFFF);
      send_item(FUNC_ACTIVATE, 64'h8000_0000_0000_0000);
      send_item(FUNC_REFRESH_REM, 64'h8000_0000_FFFF_FFFE);
      send_item(FUNC_REFRESH_REM, 64'h8000_0002_0000_0003);
      send_item(FUNC_REFRESH_DLT, 64'd0);
      send_item(FUNC_ACTIVATE, 64'd0);
      send_item(FUNC_REFRESH_DLT, '1);
      // Hold the sender off until every result is back before going on.
      wait_drained();
      write_period(32'd0);
      send_item(FUNC_ACTIVATE, 64'h7777);
      write_period(32'd5);
      send_item(FUNC_REFRESH_REM, '1);
      send_item(FUNC_REFRESH_DLT, 64'd4);
   endtask

   task automatic test_random_periods();
      logic [31:0] per;
      logic [63:0] span_top;
      logic [63:0] t;
      logic [63:0] now;
      logic [1:0]  op;
      int          pick;
      for (int ph = 0; ph < 14; ph++) begin
         case (ph)
            0:       per = 32'd1;
            1:       per = 32'hFFFF_FFFF;
            2:       per = 32'd0;
            3:       per = 32'd2;
            4, 5:    per = $urandom_range(3, 64);
            6, 7:    per = $urandom_range(100, 5000);
            8:       per = 32'h8000_0000;
            default: per = $urandom;
         endcase
         write_period(per);
         steady_flow = (ph == 5 || ph == 9);
         span_top = (per == 0) ? 64'd1000 : {32'd0, per};
         // Some phases start near the top of the time range so the clock wraps.
         t = ($urandom_range(0, 3) == 0) ? ~64'($urandom_range(0, 100000))
                                          : {$urandom, $urandom};
         send_item(FUNC_ACTIVATE, t);
         for (int i = 0; i < 120; i++) begin
            pick = $urandom_range(0, 99);
            op   = 2'($urandom_range(1, 3));
            if (pick < 3) wait_drained();
            if (pick < 10) begin
               op  = FUNC_ACTIVATE;
               now = t;
            end else if (pick < 16) begin
               now = model_base - 64'($urandom_range(1, 50));
            end else if (pick < 22) begin
               op  = 2'($urandom);
               now = {$urandom, $urandom};
            end else begin
               case ($urandom_range(0, 3))
                  0:       t = t + span_top - 64'd1 + 64'($urandom_range(0, 2));
                  1:       t = t + span_top * $urandom_range(2, 5)
                               + 64'($urandom_range(0, 64));
                  2:       t = t + ({$urandom, $urandom} % span_top);
                  default: t = t + 64'($urandom_range(0, 3));
               endcase
               now = t;
            end
            send_item(op, now);
         end
      end
      steady_flow = 1'b0;
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_directed_cases();
      test_random_periods();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   // Result sink with a random stall before each item, none while steady_flow is set.
   initial begin : rsp_sink
      int stall;
      forever begin
         stall = steady_flow ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid === 1'b1 && !reset));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            note_mismatch("unexpected result", '0, rsp_tdata[64:1]);
         end else begin
            oldest = pending_results.pop_front();
            if (rsp_tdata[0] !== oldest.expired)
               note_mismatch("expired", oldest.expired, rsp_tdata[0]);
            if (rsp_tdata[64:1] !== oldest.time_value)
               note_mismatch("time_value", oldest.time_value, rsp_tdata[64:1]);
            if (rsp_tdata[65] !== oldest.zero_err)
               note_mismatch("zero_period_error", oldest.zero_err, rsp_tdata[65]);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

endmodule
